### hdl/rsks_pkg.sv
// types, codes and result-building helpers for the record stack
// no dependencies; used by every module of the block
package rsks_pkg;

    localparam int MAX_RESULTS = 8;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DUMP  = 3'd3,
        CMD_FIND  = 3'd4,
        CMD_LIST  = 3'd5,
        CMD_COUNT = 3'd6,
        CMD_NOP   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] code;
        logic [31:0]        box_height;
        logic [31:0]        box_width;
        logic [31:0]        box_depth;
        logic [63:0]        brand_tag;
        logic [63:0]        company_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] rec_code;
        logic [31:0]        rec_height;
        logic [31:0]        rec_width;
        logic [31:0]        rec_depth;
        logic [63:0]        rec_brand;
        logic [63:0]        rec_company;
        logic [2:0]         position;
        logic [3:0]         count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] code;
        logic [31:0]        height;
        logic [31:0]        width;
        logic [31:0]        depth;
        logic [63:0]        brand;
        logic [63:0]        company;
    } t_rec;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
        logic load;
        logic shift;
    } t_cell_ctl;

    function automatic t_out_item rec_item(t_rec rec, logic [2:0] pos, logic [3:0] cnt,
                                           logic last);
        t_out_item o;
        o.status      = ST_OK;
        o.rec_code    = rec.code;
        o.rec_height  = rec.height;
        o.rec_width   = rec.width;
        o.rec_depth   = rec.depth;
        o.rec_brand   = rec.brand;
        o.rec_company = rec.company;
        o.position    = pos;
        o.count       = cnt;
        o.last        = last;
        return o;
    endfunction

    function automatic t_out_item status_item(t_status st, logic [3:0] cnt);
        t_out_item o;
        o        = '0;
        o.status = st;
        o.count  = cnt;
        o.last   = 1'b1;
        return o;
    endfunction

endpackage

### hdl/rsks_cell.sv
// one stack cell: a held record plus a scan copy that shifts toward the head
// depends on rsks_pkg
module rsks_cell (
    input  logic               i_clk,
    input  rsks_pkg::t_cell_ctl i_ctl,
    input  rsks_pkg::t_rec     i_push_rec,
    input  rsks_pkg::t_rec     i_pop_rec,
    input  rsks_pkg::t_rec     i_scan_in,
    output rsks_pkg::t_rec     o_rec,
    output rsks_pkg::t_rec     o_scan
);
    import rsks_pkg::*;

    t_rec r_rec;
    t_rec r_scan;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_rec <= i_push_rec;
        end else if (i_ctl.pop) begin
            r_rec <= i_pop_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_scan <= r_rec;
        end else if (i_ctl.shift) begin
            r_scan <= i_scan_in;
        end
    end

    assign o_rec  = r_rec;
    assign o_scan = r_scan;

endmodule

### hdl/record_stack_with_key_search.sv
// Bounded stack of records kept in a chain of cells, top of stack in the head cell. Push,
// pop, peek, count and, on an empty stack, every command but a nop are answered from idle.
// Dump, find code and list company copy the chain into its scan registers and shift it one
// record per cycle past the head cell while no match waits on a stalled output, so such a
// command passes through accept, walk and final beat, stretched by any output stall;
// find stops at its first match and a dump or list stops after eight results.
// depends on rsks_pkg and rsks_cell
module record_stack_with_key_search #(
    parameter int STACK_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsks_pkg::t_in_item  i_in_item,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output rsks_pkg::t_out_item o_out_item,
    output logic                o_out_valid,
    input  logic                i_out_stall
);
    import rsks_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_slot, n_slot;
    t_cmd      r_cmd, n_cmd;
    logic signed [31:0] r_code_key, n_code_key;
    logic [63:0] r_company_key, n_company_key;
    t_rec      r_hold, n_hold;
    logic [SW-1:0] r_hold_slot, n_hold_slot;
    logic      r_hold_valid, n_hold_valid;
    logic [3:0] r_nmatch, n_nmatch;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    t_cell_ctl cell_ctl;
    t_rec      cell_rec  [STACK_DEPTH];
    t_rec      cell_scan [STACK_DEPTH];
    t_rec      in_rec;
    t_rec      cur;
    logic      in_accept;
    logic      out_free;
    logic      match;
    logic      advance;
    logic      is_walk_cmd;

    assign in_rec.code    = i_in_item.code;
    assign in_rec.height  = i_in_item.box_height;
    assign in_rec.width   = i_in_item.box_width;
    assign in_rec.depth   = i_in_item.box_depth;
    assign in_rec.brand   = i_in_item.brand_tag;
    assign in_rec.company = i_in_item.company_tag;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            t_rec push_src;
            t_rec pop_src;
            t_rec scan_src;
            if (g == 0) begin : g_head
                assign push_src = in_rec;
            end else begin : g_body
                assign push_src = cell_rec[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_tail
                assign pop_src  = cell_rec[g];
                assign scan_src = cell_scan[g];
            end else begin : g_inner
                assign pop_src  = cell_rec[g+1];
                assign scan_src = cell_scan[g+1];
            end
            rsks_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_push_rec (push_src),
                .i_pop_rec  (pop_src),
                .i_scan_in  (scan_src),
                .o_rec      (cell_rec[g]),
                .o_scan     (cell_scan[g])
            );
        end
    endgenerate

    assign cur        = cell_scan[0];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_walk_cmd = (i_in_item.command == CMD_DUMP) || (i_in_item.command == CMD_FIND) ||
                         (i_in_item.command == CMD_LIST);

    assign match = (r_cmd == CMD_DUMP) ||
                   ((r_cmd == CMD_FIND) && (cur.code == r_code_key)) ||
                   ((r_cmd == CMD_LIST) && (cur.company == r_company_key));
    // a match with a held result must hand that one on first
    assign advance = !match || !r_hold_valid || out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && is_walk_cmd && (r_count != '0)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (match && (r_cmd == CMD_FIND)) begin
                    n_state = S_FLUSH;
                end else if (advance && ((r_slot == '0) ||
                             (match && (r_nmatch == 4'(MAX_RESULTS - 1))))) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count       = r_count;
        n_slot        = r_slot;
        n_cmd         = r_cmd;
        n_code_key    = r_code_key;
        n_company_key = r_company_key;
        n_hold        = r_hold;
        n_hold_slot   = r_hold_slot;
        n_hold_valid  = r_hold_valid;
        n_nmatch      = r_nmatch;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        cell_ctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    priority if (i_in_item.command == CMD_NOP) begin
                        n_out_valid = 1'b0;
                    end else if (i_in_item.command == CMD_PUSH) begin
                        n_out_valid = 1'b1;
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_out = status_item(ST_FULL, 4'(r_count));
                        end else begin
                            cell_ctl.push = 1'b1;
                            n_count       = r_count + 1'b1;
                            n_out = rec_item(in_rec, 3'(r_count), 4'(r_count + 1'b1), 1'b1);
                        end
                    end else if (i_in_item.command == CMD_COUNT) begin
                        n_out_valid = 1'b1;
                        n_out       = status_item(ST_OK, 4'(r_count));
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out       = status_item(ST_EMPTY, 4'(r_count));
                    end else if (i_in_item.command == CMD_POP) begin
                        n_out_valid  = 1'b1;
                        cell_ctl.pop = 1'b1;
                        n_count      = r_count - 1'b1;
                        n_out = rec_item(cell_rec[0], 3'(r_count - 1'b1),
                                         4'(r_count - 1'b1), 1'b1);
                    end else if (i_in_item.command == CMD_PEEK) begin
                        n_out_valid = 1'b1;
                        n_out = rec_item(cell_rec[0], 3'(r_count - 1'b1), 4'(r_count), 1'b1);
                    end else begin
                        // dump, find or list: snapshot the chain and walk it
                        cell_ctl.load = 1'b1;
                        n_cmd         = t_cmd'(i_in_item.command);
                        n_code_key    = i_in_item.code;
                        n_company_key = i_in_item.company_tag;
                        n_slot        = SW'(r_count - 1'b1);
                        n_hold_valid  = 1'b0;
                        n_nmatch      = '0;
                    end
                end
            end
            S_WALK: begin
                if (advance) begin
                    cell_ctl.shift = 1'b1;
                    n_slot         = r_slot - 1'b1;
                    if (match) begin
                        n_hold       = cur;
                        n_hold_slot  = r_slot;
                        n_hold_valid = 1'b1;
                        n_nmatch     = r_nmatch + 1'b1;
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out = rec_item(r_hold, 3'(r_hold_slot), 4'(r_count), 1'b0);
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_hold_valid) begin
                        n_out = rec_item(r_hold, 3'(r_hold_slot), 4'(r_count), 1'b1);
                    end else begin
                        n_out = status_item(ST_NOTFOUND, 4'(r_count));
                    end
                end
            end
            default: n_out_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
            r_nmatch     <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
            r_nmatch     <= n_nmatch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot        <= n_slot;
        r_cmd         <= n_cmd;
        r_code_key    <= n_code_key;
        r_company_key <= n_company_key;
        r_hold        <= n_hold;
        r_hold_slot   <= n_hold_slot;
        r_out         <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### hdl/rsks_check.sv
// port-level checks for the record stack, attached to the top level by bind
// depends on rsks_pkg
module rsks_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input rsks_pkg::t_out_item o_out_item,
    input logic                o_out_valid,
    input logic                i_out_stall
);
    import rsks_pkg::*;

    // a blocked result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result beat changed while stalled");

    // no new command while a result is blocked
    a_no_accept_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while result blocked");

    // mid-run beats mean the command is still being worked on
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> o_in_stall)
        else $error("input taken inside a result run");

    // status-only beats end their run and carry no record
    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |->
        (o_out_item.last && (o_out_item.rec_code == 0) && (o_out_item.position == 3'd0)))
        else $error("bad status beat");

endmodule

bind record_stack_with_key_search rsks_check u_check (.*);
